@@ rtl/vmu_pkg.sv @@
// Shared types, constants and helper functions for the vector math unit.
package vmu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SAT_W      = PROD_W + 4;
    localparam int SQRT_STEPS = DATA_WIDTH;
    localparam int QUO_W      = DATA_WIDTH + FRAC_BITS;
    // mul: 2, sqrt: steps + round, div: entry + steps + round, output: 1
    localparam int PIPE_DEPTH = 2 + SQRT_STEPS + 1 + 1 + QUO_W + 1 + 1;

    localparam logic [3:0] MODE_ADD       = 4'd0;
    localparam logic [3:0] MODE_SUB       = 4'd1;
    localparam logic [3:0] MODE_DOT       = 4'd2;
    localparam logic [3:0] MODE_SCALE     = 4'd3;
    localparam logic [3:0] MODE_DIVIDE    = 4'd4;
    localparam logic [3:0] MODE_EQUAL     = 4'd5;
    localparam logic [3:0] MODE_LEN2      = 4'd6;
    localparam logic [3:0] MODE_LEN       = 4'd7;
    localparam logic [3:0] MODE_NORMALIZE = 4'd8;
    localparam logic [3:0] MODE_CROSS     = 4'd9;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [3:0] mode;
        data_t      ax;
        data_t      ay;
        data_t      az;
        data_t      bx;
        data_t      by_comp;
        data_t      bz;
        data_t      scale_factor;
    } in_word_t;

    typedef struct packed {
        data_t rx;
        data_t ry;
        data_t rz;
        data_t scalar_result;
        logic  equal_flag;
        logic  saturated_flag;
        logic  div_zero_flag;
    } out_word_t;

    // word context carried down the pipe
    typedef struct packed {
        logic [3:0]                 mode;
        logic [2:0][DATA_WIDTH-1:0] a;
        logic [2:0][DATA_WIDTH-1:0] b;
        logic [2:0][DATA_WIDTH-1:0] r;
        logic [DATA_WIDTH-1:0]      sc;
        logic                       eq;
        logic                       sat;
        logic                       dz;
        logic [PROD_W-1:0]          acc;
        logic [DATA_WIDTH-1:0]      root;
    } ctx_t;

    // one divider lane
    typedef struct packed {
        logic [DATA_WIDTH-1:0] ua;
        logic [DATA_WIDTH-1:0] ud;
        logic [DATA_WIDTH-1:0] rem;
        logic [QUO_W-1:0]      q;
        logic                  neg;
    } lane_t;

    typedef struct packed {
        data_t value;
        logic  clipped;
    } sat_t;

    function automatic sat_t saturate(input logic signed [SAT_W-1:0] v);
        sat_t s;
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = {{(SAT_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
        lo = {{(SAT_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
        if (v > hi) begin
            s.value   = DATA_MAX;
            s.clipped = 1'b1;
        end else if (v < lo) begin
            s.value   = DATA_MIN;
            s.clipped = 1'b1;
        end else begin
            s.value   = v[DATA_WIDTH-1:0];
            s.clipped = 1'b0;
        end
        return s;
    endfunction

    // half LSB up, then arithmetic shift: ties toward +inf
    function automatic logic signed [SAT_W-1:0] round_frac(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] t;
        t = v + (SAT_W'(1) << (FRAC_BITS - 1));
        return t >>> FRAC_BITS;
    endfunction

endpackage

@@ rtl/vmu_mul.sv @@
// Operand select, product stage and combine stage of the vector math unit.
module vmu_mul
    import vmu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  in_word_t in_word,
    output logic     out_valid,
    output ctx_t     out_ctx
);

    data_t                   m_a [6];
    data_t                   m_b [6];
    logic                    s1_valid_reg;
    in_word_t                s1_word_reg;
    logic signed [PROD_W-1:0] prod_reg  [6];
    logic signed [PROD_W-1:0] prod_next [6];

    logic                    s2_valid_reg;
    ctx_t                    ctx_reg;
    ctx_t                    ctx_next;

    data_t                   va [3];
    data_t                   vb [3];
    logic signed [SAT_W-1:0] sum3;
    sat_t                    sat_dot;
    sat_t                    sat_add   [3];
    sat_t                    sat_sub   [3];
    sat_t                    sat_scale [3];
    sat_t                    sat_cross [3];

    always_comb
    begin
        m_a[0] = in_word.ax;  m_b[0] = in_word.bx;
        m_a[1] = in_word.ay;  m_b[1] = in_word.by_comp;
        m_a[2] = in_word.az;  m_b[2] = in_word.bz;
        m_a[3] = in_word.az;  m_b[3] = in_word.by_comp;
        m_a[4] = in_word.ax;  m_b[4] = in_word.bz;
        m_a[5] = in_word.ay;  m_b[5] = in_word.bx;
        unique case (in_word.mode)
            MODE_SCALE:
            begin
                m_b[0] = in_word.scale_factor;
                m_b[1] = in_word.scale_factor;
                m_b[2] = in_word.scale_factor;
            end
            MODE_LEN2, MODE_LEN, MODE_NORMALIZE:
            begin
                m_b[0] = in_word.ax;
                m_b[1] = in_word.ay;
                m_b[2] = in_word.az;
            end
            MODE_CROSS:
            begin
                m_a[0] = in_word.ay;  m_b[0] = in_word.bz;
                m_a[1] = in_word.az;  m_b[1] = in_word.bx;
                m_a[2] = in_word.ax;  m_b[2] = in_word.by_comp;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < 6; i++)
        begin
            prod_next[i] = PROD_W'(m_a[i]) * PROD_W'(m_b[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg <= in_word;
        prod_reg    <= prod_next;
        ctx_reg     <= ctx_next;
    end

    always_comb
    begin
        va[0] = s1_word_reg.ax;  vb[0] = s1_word_reg.bx;
        va[1] = s1_word_reg.ay;  vb[1] = s1_word_reg.by_comp;
        va[2] = s1_word_reg.az;  vb[2] = s1_word_reg.bz;
        sum3 = SAT_W'(prod_reg[0]) + SAT_W'(prod_reg[1]) + SAT_W'(prod_reg[2]);
        sat_dot = saturate(round_frac(sum3));
        for (int i = 0; i < 3; i++)
        begin
            sat_add[i]   = saturate(SAT_W'(va[i]) + SAT_W'(vb[i]));
            sat_sub[i]   = saturate(SAT_W'(va[i]) - SAT_W'(vb[i]));
            sat_scale[i] = saturate(round_frac(SAT_W'(prod_reg[i])));
            sat_cross[i] = saturate(round_frac(SAT_W'(prod_reg[i]) - SAT_W'(prod_reg[i+3])));
        end

        ctx_next.mode = s1_word_reg.mode;
        for (int i = 0; i < 3; i++)
        begin
            ctx_next.a[i] = va[i];
            ctx_next.b[i] = vb[i];
        end
        ctx_next.r    = '0;
        ctx_next.sc   = '0;
        ctx_next.eq   = 1'b0;
        ctx_next.sat  = 1'b0;
        ctx_next.dz   = 1'b0;
        ctx_next.acc  = sum3[PROD_W-1:0];
        ctx_next.root = '0;

        case (s1_word_reg.mode)
            MODE_ADD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ctx_next.r[i] = sat_add[i].value;
                end
                ctx_next.sat = sat_add[0].clipped | sat_add[1].clipped | sat_add[2].clipped;
            end
            MODE_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ctx_next.r[i] = sat_sub[i].value;
                end
                ctx_next.sat = sat_sub[0].clipped | sat_sub[1].clipped | sat_sub[2].clipped;
            end
            MODE_DOT, MODE_LEN2:
            begin
                ctx_next.sc  = sat_dot.value;
                ctx_next.sat = sat_dot.clipped;
            end
            MODE_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ctx_next.r[i] = sat_scale[i].value;
                end
                ctx_next.sat = sat_scale[0].clipped | sat_scale[1].clipped
                             | sat_scale[2].clipped;
            end
            MODE_EQUAL:
            begin
                ctx_next.eq = (va[0] == vb[0]) && (va[1] == vb[1]) && (va[2] == vb[2]);
            end
            MODE_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ctx_next.r[i] = sat_cross[i].value;
                end
                ctx_next.sat = sat_cross[0].clipped | sat_cross[1].clipped
                             | sat_cross[2].clipped;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = s2_valid_reg;
    assign out_ctx   = ctx_reg;

endmodule

@@ rtl/vmu_sqrt.sv @@
// Pipelined rounded integer square root of the sum of squares, one bit per stage.
module vmu_sqrt
    import vmu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  ctx_t in_ctx,
    output logic out_valid,
    output ctx_t out_ctx
);

    logic                  valid_reg [SQRT_STEPS];
    ctx_t                  ctx_reg   [SQRT_STEPS];
    logic [DATA_WIDTH:0]   rem_reg   [SQRT_STEPS];
    logic [DATA_WIDTH:0]   rem_next  [SQRT_STEPS];
    logic [DATA_WIDTH-1:0] root_reg  [SQRT_STEPS];
    logic [DATA_WIDTH-1:0] root_next [SQRT_STEPS];

    logic                  rnd_valid_reg;
    ctx_t                  rnd_ctx_reg;
    ctx_t                  rnd_ctx_next;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic                  vin;
        ctx_t                  cin;
        logic [DATA_WIDTH:0]   rin;
        logic [DATA_WIDTH-1:0] qin;
        logic [DATA_WIDTH+2:0] rem_shift;
        logic [DATA_WIDTH+2:0] trial;

        if (k == 0)
        begin : g_first
            assign vin = in_valid;
            assign cin = in_ctx;
            assign rin = '0;
            assign qin = '0;
        end
        else
        begin : g_rest
            assign vin = valid_reg[k-1];
            assign cin = ctx_reg[k-1];
            assign rin = rem_reg[k-1];
            assign qin = root_reg[k-1];
        end

        always_comb
        begin
            rem_shift = {rin, cin.acc[PROD_W-1-2*k -: 2]};
            trial     = {1'b0, qin, 2'b01};
            if (rem_shift >= trial)
            begin
                rem_next[k]  = (DATA_WIDTH+1)'(rem_shift - trial);
                root_next[k] = {qin[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_shift[DATA_WIDTH:0];
                root_next[k] = {qin[DATA_WIDTH-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            ctx_reg[k]  <= cin;
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
        end
    end

    // round to nearest: bump when remainder exceeds the root
    always_comb
    begin
        rnd_ctx_next      = ctx_reg[SQRT_STEPS-1];
        rnd_ctx_next.root = root_reg[SQRT_STEPS-1]
                          + DATA_WIDTH'(rem_reg[SQRT_STEPS-1] > {1'b0, root_reg[SQRT_STEPS-1]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
        end
        else
        begin
            rnd_valid_reg <= valid_reg[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_ctx_reg <= rnd_ctx_next;
    end

    assign out_valid = rnd_valid_reg;
    assign out_ctx   = rnd_ctx_reg;

endmodule

@@ rtl/vmu_div.sv @@
// Three-lane pipelined restoring divider, one quotient bit per stage, with rounding.
module vmu_div
    import vmu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  ctx_t        in_ctx,
    output logic        out_valid,
    output ctx_t        out_ctx,
    output lane_t [2:0] out_lanes
);

    logic        ent_valid_reg;
    ctx_t        ent_ctx_reg;
    lane_t [2:0] ent_lane_reg;
    lane_t [2:0] ent_lane_next;

    logic        valid_reg [QUO_W];
    ctx_t        ctx_reg   [QUO_W];
    lane_t [2:0] lane_reg  [QUO_W];
    lane_t [2:0] lane_next [QUO_W];

    logic        rnd_valid_reg;
    ctx_t        rnd_ctx_reg;
    lane_t [2:0] rnd_lane_reg;
    lane_t [2:0] rnd_lane_next;

    data_t       dvd [3];
    data_t       dvs [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dvd[i] = in_ctx.a[i];
            dvs[i] = in_ctx.b[i];
            ent_lane_next[i].ua  = dvd[i][DATA_WIDTH-1] ? (~dvd[i] + 1'b1) : dvd[i];
            ent_lane_next[i].rem = '0;
            ent_lane_next[i].q   = '0;
            if (in_ctx.mode == MODE_DIVIDE)
            begin
                ent_lane_next[i].ud  = dvs[i][DATA_WIDTH-1] ? (~dvs[i] + 1'b1) : dvs[i];
                ent_lane_next[i].neg = dvd[i][DATA_WIDTH-1] ^ dvs[i][DATA_WIDTH-1];
            end
            else
            begin
                ent_lane_next[i].ud  = in_ctx.root;
                ent_lane_next[i].neg = dvd[i][DATA_WIDTH-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_ctx_reg  <= in_ctx;
        ent_lane_reg <= ent_lane_next;
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic        vin;
        ctx_t        cin;
        lane_t [2:0] lin;
        logic [DATA_WIDTH:0] rem_shift [3];

        if (k == 0)
        begin : g_first
            assign vin = ent_valid_reg;
            assign cin = ent_ctx_reg;
            assign lin = ent_lane_reg;
        end
        else
        begin : g_rest
            assign vin = valid_reg[k-1];
            assign cin = ctx_reg[k-1];
            assign lin = lane_reg[k-1];
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                lane_next[k][i] = lin[i];
                // numerator is ua followed by FRAC_BITS zeros
                if (k < DATA_WIDTH)
                begin
                    rem_shift[i] = {lin[i].rem, lin[i].ua[(DATA_WIDTH-1-k) % DATA_WIDTH]};
                end
                else
                begin
                    rem_shift[i] = {lin[i].rem, 1'b0};
                end
                if (rem_shift[i] >= {1'b0, lin[i].ud})
                begin
                    lane_next[k][i].rem = DATA_WIDTH'(rem_shift[i] - {1'b0, lin[i].ud});
                    lane_next[k][i].q   = {lin[i].q[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    lane_next[k][i].rem = rem_shift[i][DATA_WIDTH-1:0];
                    lane_next[k][i].q   = {lin[i].q[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            ctx_reg[k]  <= cin;
            lane_reg[k] <= lane_next[k];
        end
    end

    // round magnitude to nearest, ties away from zero
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd_lane_next[i]   = lane_reg[QUO_W-1][i];
            rnd_lane_next[i].q = lane_reg[QUO_W-1][i].q
                + QUO_W'({lane_reg[QUO_W-1][i].rem, 1'b0} >= {1'b0, lane_reg[QUO_W-1][i].ud});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
        end
        else
        begin
            rnd_valid_reg <= valid_reg[QUO_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_ctx_reg  <= ctx_reg[QUO_W-1];
        rnd_lane_reg <= rnd_lane_next;
    end

    assign out_valid = rnd_valid_reg;
    assign out_ctx   = rnd_ctx_reg;
    assign out_lanes = rnd_lane_reg;

endmodule

@@ rtl/vector3_math_unit_core.sv @@
// Top level of the three-component Q16.16 vector math unit.
// A word is taken on every cycle that start is high; busy never rises.
// Every word, whatever its op, runs through the product stages, the square
// root pipeline (one root bit per stage) and the divider pipeline (one
// quotient bit per stage, three lanes) so results stay in order, and leaves
// with done high for one cycle.
module vector3_math_unit_core
    import vmu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  request,
    output logic      done,
    output out_word_t result
);

    logic        mul_valid;
    ctx_t        mul_ctx;
    logic        sqrt_valid;
    ctx_t        sqrt_ctx;
    logic        div_valid;
    ctx_t        div_ctx;
    lane_t [2:0] div_lanes;

    logic        done_reg;
    out_word_t   result_reg;
    out_word_t   result_next;

    data_t       qval [3];
    logic        clip [3];
    data_t       av   [3];
    data_t       bv   [3];
    logic        fits [3];
    logic [DATA_WIDTH-1:0] rvec [3];
    logic        sat_any;
    logic        dz_any;
    data_t       sc_val;

    assign busy = 1'b0;

    vmu_mul u_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_word   (request),
        .out_valid (mul_valid),
        .out_ctx   (mul_ctx)
    );

    vmu_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ctx    (mul_ctx),
        .out_valid (sqrt_valid),
        .out_ctx   (sqrt_ctx)
    );

    vmu_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqrt_valid),
        .in_ctx    (sqrt_ctx),
        .out_valid (div_valid),
        .out_ctx   (div_ctx),
        .out_lanes (div_lanes)
    );

    always_comb
    begin
        sat_any = div_ctx.sat;
        dz_any  = div_ctx.dz;
        sc_val  = div_ctx.sc;
        for (int i = 0; i < 3; i++)
        begin
            av[i]   = div_ctx.a[i];
            bv[i]   = div_ctx.b[i];
            rvec[i] = div_ctx.r[i];
            if (div_lanes[i].neg)
            begin
                fits[i] = div_lanes[i].q <= QUO_W'({1'b1, {(DATA_WIDTH-1){1'b0}}});
            end
            else
            begin
                fits[i] = div_lanes[i].q <= QUO_W'({(DATA_WIDTH-1){1'b1}});
            end
            if (!fits[i])
            begin
                qval[i] = div_lanes[i].neg ? DATA_MIN : DATA_MAX;
            end
            else if (div_lanes[i].neg)
            begin
                qval[i] = ~div_lanes[i].q[DATA_WIDTH-1:0] + 1'b1;
            end
            else
            begin
                qval[i] = div_lanes[i].q[DATA_WIDTH-1:0];
            end
            clip[i] = !fits[i];
        end

        case (div_ctx.mode)
            MODE_DIVIDE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (bv[i] == '0)
                    begin
                        dz_any = 1'b1;
                        if (av[i] > 0)
                        begin
                            rvec[i] = DATA_MAX;
                        end
                        else if (av[i] < 0)
                        begin
                            rvec[i] = DATA_MIN;
                        end
                        else
                        begin
                            rvec[i] = '0;
                        end
                    end
                    else
                    begin
                        rvec[i] = qval[i];
                        sat_any = sat_any | clip[i];
                    end
                end
            end
            MODE_NORMALIZE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (div_ctx.acc == '0)
                    begin
                        rvec[i] = av[i];
                    end
                    else
                    begin
                        rvec[i] = qval[i];
                        sat_any = sat_any | clip[i];
                    end
                end
            end
            MODE_LEN:
            begin
                if (div_ctx.root[DATA_WIDTH-1])
                begin
                    sc_val  = DATA_MAX;
                    sat_any = 1'b1;
                end
                else
                begin
                    sc_val = div_ctx.root;
                end
            end
            default:
            begin
            end
        endcase

        result_next.rx             = rvec[0];
        result_next.ry             = rvec[1];
        result_next.rz             = rvec[2];
        result_next.scalar_result  = sc_val;
        result_next.equal_flag     = div_ctx.eq;
        result_next.saturated_flag = sat_any;
        result_next.div_zero_flag  = dz_any;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##PIPE_DEPTH done)
        else $error("word did not leave after the pipeline depth");

    a_eq_alone : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.equal_flag |-> !result.saturated_flag && !result.div_zero_flag
            && result.scalar_result == '0)
        else $error("equal flag raised with other results");

    a_dz_vector : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.div_zero_flag |-> result.scalar_result == '0 && !result.equal_flag)
        else $error("divide by zero flag on a scalar result");
`endif

endmodule

@@ test/vector3_math_unit_core_tb.sv @@
// Self-checking testbench for vector3_math_unit_core: directed table, then random ops.
`timescale 1ns / 100ps

module vector3_math_unit_core_tb;
    import vmu_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t want;
    } row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  request;
    logic      done;
    out_word_t result;

    out_word_t pending_results[$];
    int        fail_count;
    row_t      rows[$];

    vector3_math_unit_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic data_t clamp(input wide_t v, inout logic sat);
        if (v > wide_t'(DATA_MAX))
        begin
            sat = 1'b1;
            return DATA_MAX;
        end
        if (v < wide_t'(DATA_MIN))
        begin
            sat = 1'b1;
            return DATA_MIN;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    function automatic wide_t round_q(input wide_t v);
        wide_t t;
        t = v + (wide_t'(1) <<< (FRAC_BITS - 1));
        return t >>> FRAC_BITS;
    endfunction

    function automatic wide_t root_round(input wide_t x);
        wide_t r;
        wide_t c;
        r = 0;
        for (int bit_i = DATA_WIDTH; bit_i >= 0; bit_i--)
        begin
            c = r | (wide_t'(1) <<< bit_i);
            if (c * c <= x)
                r = c;
        end
        if (x - r * r > r)
            r = r + 1;
        return r;
    endfunction

    function automatic data_t quotient(input wide_t a, input wide_t d, inout logic sat);
        wide_t ua;
        wide_t ud;
        wide_t num;
        wide_t q;
        wide_t rem;
        ua  = (a < 0) ? -a : a;
        ud  = (d < 0) ? -d : d;
        num = ua <<< FRAC_BITS;
        q   = num / ud;
        rem = num % ud;
        if (rem >= ud - rem)
            q = q + 1;
        if ((a < 0) != (d < 0))
            q = -q;
        return clamp(q, sat);
    endfunction

    function automatic out_word_t vec_op(input in_word_t w);
        out_word_t o;
        wide_t     a[3];
        wide_t     b[3];
        wide_t     s;
        wide_t     acc;
        wide_t     n;
        logic      sat;
        data_t     r[3];
        o = '0;
        sat = 1'b0;
        r[0] = '0;
        r[1] = '0;
        r[2] = '0;
        a[0] = w.ax;
        a[1] = w.ay;
        a[2] = w.az;
        b[0] = w.bx;
        b[1] = w.by_comp;
        b[2] = w.bz;
        s    = w.scale_factor;
        acc  = 0;
        case (w.mode)
            MODE_ADD:
                for (int i = 0; i < 3; i++) r[i] = clamp(a[i] + b[i], sat);
            MODE_SUB:
                for (int i = 0; i < 3; i++) r[i] = clamp(a[i] - b[i], sat);
            MODE_DOT:
            begin
                for (int i = 0; i < 3; i++) acc = acc + a[i] * b[i];
                o.scalar_result = clamp(round_q(acc), sat);
            end
            MODE_SCALE:
                for (int i = 0; i < 3; i++) r[i] = clamp(round_q(a[i] * s), sat);
            MODE_DIVIDE:
                for (int i = 0; i < 3; i++)
                begin
                    if (b[i] == 0)
                    begin
                        o.div_zero_flag = 1'b1;
                        r[i] = (a[i] > 0) ? DATA_MAX : ((a[i] < 0) ? DATA_MIN : '0);
                    end
                    else
                        r[i] = quotient(a[i], b[i], sat);
                end
            MODE_EQUAL:
                o.equal_flag = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
            MODE_LEN2, MODE_LEN, MODE_NORMALIZE:
            begin
                for (int i = 0; i < 3; i++) acc = acc + a[i] * a[i];
                if (w.mode == MODE_LEN2)
                    o.scalar_result = clamp(round_q(acc), sat);
                else if (w.mode == MODE_LEN)
                    o.scalar_result = clamp(root_round(acc), sat);
                else if (acc == 0)
                    for (int i = 0; i < 3; i++) r[i] = a[i][DATA_WIDTH-1:0];
                else
                begin
                    n = root_round(acc);
                    for (int i = 0; i < 3; i++) r[i] = quotient(a[i], n, sat);
                end
            end
            MODE_CROSS:
            begin
                r[0] = clamp(round_q(a[1] * b[2] - a[2] * b[1]), sat);
                r[1] = clamp(round_q(a[2] * b[0] - a[0] * b[2]), sat);
                r[2] = clamp(round_q(a[0] * b[1] - a[1] * b[0]), sat);
            end
            default: ;
        endcase
        o.rx = r[0];
        o.ry = r[1];
        o.rz = r[2];
        o.saturated_flag = sat;
        return o;
    endfunction

    function automatic in_word_t mk(input logic [3:0] m, input data_t ax, input data_t ay,
                                    input data_t az, input data_t bx, input data_t by_c,
                                    input data_t bz, input data_t sf);
        in_word_t w;
        w.mode = m;
        w.ax = ax;
        w.ay = ay;
        w.az = az;
        w.bx = bx;
        w.by_comp = by_c;
        w.bz = bz;
        w.scale_factor = sf;
        return w;
    endfunction

    function automatic out_word_t mo(input data_t rx, input data_t ry, input data_t rz,
                                     input data_t sc, input logic eq, input logic sat,
                                     input logic dz);
        out_word_t o;
        o.rx = rx;
        o.ry = ry;
        o.rz = rz;
        o.scalar_result = sc;
        o.equal_flag = eq;
        o.saturated_flag = sat;
        o.div_zero_flag = dz;
        return o;
    endfunction

    function automatic data_t pick_value();
        case ($urandom_range(0, 5))
            0:
                case ($urandom_range(0, 4))
                    0: return DATA_MAX;
                    1: return DATA_MIN;
                    2: return '0;
                    3: return data_t'(32'sh10000);
                    default: return data_t'(-32'sh10000);
                endcase
            1, 2: return data_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return data_t'($urandom);
        endcase
    endfunction

    task automatic add_row(input in_word_t w, input bit typed, input out_word_t want);
        row_t r;
        r.word = w;
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endtask

    task automatic issue(input in_word_t w, input bit typed, input out_word_t want);
        start <= 1'b1;
        request <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(typed ? want : vec_op(w));
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
    endtask

    // sample mid-cycle, the values registered at the last rising edge
    always @(negedge clk)
    begin
        out_word_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with none expected");
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (result.rx !== e.rx)
                begin
                    $error("rx: expected %h, got %h", e.rx, result.rx);
                    fail_count++;
                end
                if (result.ry !== e.ry)
                begin
                    $error("ry: expected %h, got %h", e.ry, result.ry);
                    fail_count++;
                end
                if (result.rz !== e.rz)
                begin
                    $error("rz: expected %h, got %h", e.rz, result.rz);
                    fail_count++;
                end
                if (result.scalar_result !== e.scalar_result)
                begin
                    $error("scalar_result: expected %h, got %h", e.scalar_result,
                           result.scalar_result);
                    fail_count++;
                end
                if (result.equal_flag !== e.equal_flag)
                begin
                    $error("equal_flag: expected %b, got %b", e.equal_flag, result.equal_flag);
                    fail_count++;
                end
                if (result.saturated_flag !== e.saturated_flag)
                begin
                    $error("saturated_flag: expected %b, got %b", e.saturated_flag,
                           result.saturated_flag);
                    fail_count++;
                end
                if (result.div_zero_flag !== e.div_zero_flag)
                begin
                    $error("div_zero_flag: expected %b, got %b", e.div_zero_flag,
                           result.div_zero_flag);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        in_word_t w;
        data_t    one;
        data_t    m1;
        int       total;
        int       wait_cycles;
        one = data_t'(32'sh10000);
        m1  = data_t'(-32'sh10000);
        fail_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;

        // directed table
        add_row(mk(MODE_ADD, 0, 0, 0, 0, 0, 0, 0), 1, mo(0, 0, 0, 0, 0, 0, 0));
        add_row(mk(MODE_ADD, DATA_MAX, DATA_MIN, 1, DATA_MAX, DATA_MIN, -1, 0), 1,
                mo(DATA_MAX, DATA_MIN, 0, 0, 0, 1, 0));
        add_row(mk(MODE_SUB, DATA_MIN, DATA_MAX, one, 1, -1, one, 0), 1,
                mo(DATA_MIN, DATA_MAX, 0, 0, 0, 1, 0));
        add_row(mk(MODE_DOT, one, one, one, one, m1, one, 0), 0, '0);
        add_row(mk(MODE_DOT, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, 0),
                1, mo(0, 0, 0, DATA_MAX, 0, 1, 0));
        add_row(mk(MODE_SCALE, DATA_MIN, DATA_MAX, 1, 0, 0, 0, DATA_MIN), 0, '0);
        add_row(mk(MODE_SCALE, 3, -3, 1, 0, 0, 0, data_t'(32'sh8000)), 0, '0);
        add_row(mk(MODE_DIVIDE, one, m1, 0, 0, 0, 0, 0), 1,
                mo(DATA_MAX, DATA_MIN, 0, 0, 0, 0, 1));
        add_row(mk(MODE_DIVIDE, DATA_MAX, DATA_MIN, 7, 1, 1, -3, 0), 0, '0);
        add_row(mk(MODE_DIVIDE, 1, -1, DATA_MIN, 2, 2, m1, 0), 0, '0);
        add_row(mk(MODE_EQUAL, 5, -5, DATA_MIN, 5, -5, DATA_MIN, 0), 1,
                mo(0, 0, 0, 0, 1, 0, 0));
        add_row(mk(MODE_EQUAL, 5, -5, DATA_MIN, 5, -5, DATA_MAX, 0), 1, mo(0, 0, 0, 0, 0, 0, 0));
        add_row(mk(MODE_LEN2, DATA_MIN, DATA_MIN, DATA_MIN, 0, 0, 0, 0), 1,
                mo(0, 0, 0, DATA_MAX, 0, 1, 0));
        add_row(mk(MODE_LEN2, one, m1, 1, 0, 0, 0, 0), 0, '0);
        add_row(mk(MODE_LEN, DATA_MIN, DATA_MIN, DATA_MIN, 0, 0, 0, 0), 1,
                mo(0, 0, 0, DATA_MAX, 0, 1, 0));
        add_row(mk(MODE_LEN, data_t'(3 << 16), data_t'(4 << 16), 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(MODE_NORMALIZE, 0, 0, 0, 9, 9, 9, 9), 1, mo(0, 0, 0, 0, 0, 0, 0));
        add_row(mk(MODE_NORMALIZE, 0, 0, 1, 0, 0, 0, 0), 0, '0);
        add_row(mk(MODE_NORMALIZE, DATA_MAX, DATA_MIN, 12345, 0, 0, 0, 0), 0, '0);
        add_row(mk(MODE_CROSS, one, 0, 0, 0, one, 0, 0), 1, mo(0, 0, one, 0, 0, 0, 0));
        add_row(mk(MODE_CROSS, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, 0),
                0, '0);
        add_row(mk(4'd10, 1, 2, 3, 4, 5, 6, 7), 1, '0);
        add_row(mk(4'd15, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN,
                   DATA_MIN), 1, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            issue(rows[i].word, rows[i].typed, rows[i].want);
            if ($urandom_range(0, 3) == 0)
                idle_burst();
        end

        total = 800;
        for (int n = 0; n < total; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                w.mode = 4'($urandom_range(10, 15));
            else
                w.mode = 4'($urandom_range(0, 9));
            w.ax = pick_value();
            w.ay = pick_value();
            w.az = pick_value();
            w.bx = pick_value();
            w.by_comp = pick_value();
            w.bz = pick_value();
            w.scale_factor = pick_value();
            if (w.mode == MODE_EQUAL && $urandom_range(0, 1) == 1)
            begin
                w.bx = w.ax;
                w.by_comp = w.ay;
                w.bz = ($urandom_range(0, 2) == 0) ? ~w.az : w.az;
            end
            issue(w, 0, '0);
            if (n < total - 100 && $urandom_range(0, 3) == 0)
                idle_burst();
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (PIPE_DEPTH + 20) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/vmu_pkg.sv
rtl/vmu_mul.sv
rtl/vmu_sqrt.sv
rtl/vmu_div.sv
rtl/vector3_math_unit_core.sv
test/vector3_math_unit_core_tb.sv
